@@ src/rccl_pkg.sv @@
// ----------------------------------------------------------------------------
// rccl_pkg: shared types and constants of the reference clock estimator
// Field widths, limits of the estimate, result status codes and the state
// types of the controller and the serial multiply/divide unit.
// ----------------------------------------------------------------------------
package rccl_pkg;

  // Field widths
  localparam int unsigned RefW   = 29;
  localparam int unsigned MeasW  = 32;
  localparam int unsigned TgtW   = 24;
  localparam int unsigned IterW  = 4;
  localparam int unsigned ProdW  = RefW + MeasW;
  localparam int unsigned CntW   = $clog2(ProdW);

  // Estimate limits and run settings
  localparam logic [RefW-1:0]  StartEstimate = RefW'(100000000);
  localparam logic [MeasW-1:0] MinEstimate   = MeasW'(1000000);
  localparam logic [MeasW-1:0] MaxEstimate   = MeasW'(400000000);
  localparam logic [TgtW-1:0]  TargetReset   = TgtW'(115200);
  localparam logic [IterW-1:0] MaxIterations = IterW'(12);

  // Convergence test: diff * 200 <= target only for diff below 2^17
  localparam int unsigned DiffW = 17;

  typedef enum logic [1:0] {
    ST_CONTINUE  = 2'd0,
    ST_CONVERGED = 2'd1,
    ST_FAILED    = 2'd2,
    ST_LIMIT     = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIFF,
    S_CHECK,
    S_RUN,
    S_FINAL
  } state_e;

  typedef enum logic [1:0] {
    MD_IDLE,
    MD_MUL,
    MD_DIV
  } md_phase_e;

  // Result of the serial multiply/divide unit
  typedef struct packed {
    logic             done;
    logic             ovf;
    logic [MeasW-1:0] quot;
  } md_res_t;

endpackage

@@ src/rccl_if.sv @@
// ----------------------------------------------------------------------------
// rccl_meas_if / rccl_res_if: request channels of the estimator
// Valid/ready channels carrying one measurement or one result per request.
// ----------------------------------------------------------------------------
interface rccl_meas_if;
  logic                        valid;
  logic                        ready;
  logic [rccl_pkg::MeasW-1:0]  measured_baud;

  modport source (output valid, output measured_baud, input ready);
  modport sink   (input valid, input measured_baud, output ready);
endinterface

interface rccl_res_if;
  logic                        valid;
  logic                        ready;
  logic [rccl_pkg::RefW-1:0]   ref_clock_hz;
  logic [rccl_pkg::IterW-1:0]  iteration;
  logic [1:0]                  status;

  modport source (output valid, output ref_clock_hz, output iteration, output status,
                  input ready);
  modport sink   (input valid, input ref_clock_hz, input iteration, input status,
                  output ready);
endinterface

@@ src/rccl_muldiv.sv @@
// ----------------------------------------------------------------------------
// rccl_muldiv: bit-serial estimate * measurement / target
// Shift-add multiply, one measurement bit per cycle, then restoring division
// of the 61-bit product, one quotient bit per cycle, in the same register.
// ----------------------------------------------------------------------------
module rccl_muldiv (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [rccl_pkg::RefW-1:0]  est_i,
  input  logic [rccl_pkg::MeasW-1:0] meas_i,
  input  logic [rccl_pkg::TgtW-1:0]  target_i,
  output rccl_pkg::md_res_t          res_o
);
  import rccl_pkg::*;

  localparam logic [CntW-1:0] MulLast = CntW'(MeasW - 1);
  localparam logic [CntW-1:0] DivLast = CntW'(ProdW - 1);

  md_phase_e         phase_q, phase_d;
  logic [CntW-1:0]   cnt_q, cnt_d;
  logic [ProdW-1:0]  p_q, p_d;
  logic [TgtW-1:0]   r_q, r_d;
  logic              done_q, done_d;

  logic [RefW:0]     mul_sum;
  logic [TgtW+1:0]   div_trial;
  logic              div_geq;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    unique case (phase_q)
      MD_IDLE: if (start_i) phase_d = MD_MUL;
      MD_MUL:  if (cnt_q == '0) phase_d = MD_DIV;
      MD_DIV:  if (cnt_q == '0) phase_d = MD_IDLE;
      default: phase_d = MD_IDLE;
    endcase
  end

  // Datapath: one product bit or one quotient bit per cycle
  always_comb begin
    mul_sum   = {1'b0, p_q[ProdW-1:MeasW]} + (p_q[0] ? {1'b0, est_i} : '0);
    div_trial = {1'b0, r_q, p_q[ProdW-1]} - {2'b00, target_i};
    div_geq   = ~div_trial[TgtW+1];
    p_d       = p_q;
    r_d       = r_q;
    cnt_d     = cnt_q;
    done_d    = 1'b0;
    unique case (phase_q)
      MD_IDLE: begin
        if (start_i) begin
          p_d   = {{RefW{1'b0}}, meas_i};
          r_d   = '0;
          cnt_d = MulLast;
        end
      end
      MD_MUL: begin
        p_d   = {mul_sum, p_q[MeasW-1:1]};
        cnt_d = (cnt_q == '0) ? DivLast : cnt_q - 1'b1;
      end
      MD_DIV: begin
        p_d    = {p_q[ProdW-2:0], div_geq};
        r_d    = div_geq ? div_trial[TgtW-1:0] : {r_q[TgtW-2:0], p_q[ProdW-1]};
        cnt_d  = cnt_q - 1'b1;
        done_d = (cnt_q == '0);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= MD_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    p_q <= p_d;
    r_q <= r_d;
  end

  // Quotient wider than 32 bits is flagged
  assign res_o.done = done_q;
  assign res_o.ovf  = |p_q[ProdW-1:MeasW];
  assign res_o.quot = p_q[MeasW-1:0];

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> phase_q == MD_IDLE)
    else $error("muldiv done while busy");
  a_mul_to_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == MD_MUL && cnt_q == '0) |=> phase_q == MD_DIV && cnt_q == DivLast)
    else $error("multiply did not hand over to divide");
  a_div_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == MD_DIV && cnt_q == '0) |=> done_q)
    else $error("divide end without done");

endmodule

@@ src/ref_clock_convergence_loop.sv @@
// ----------------------------------------------------------------------------
// ref_clock_convergence_loop: closed-loop reference clock estimator
// Takes baud rates measured at the current estimate and either ends the run
// (converged, failed, iteration limit) or rescales the estimate by
// measured/target and asks for another measurement.
//
//   channel      dir  signals                                   
//   meas_i       in   valid, ready, measured_baud[31:0]
//   result_o     out  valid, ready, ref_clock_hz[28:0], iteration[3:0], status[1:0]
//   cfg          in   cfg_we_i, cfg_wdata_i[23:0] (target baud)
//
// A request that ends early (zero input or converged) passes the idle, diff,
// check and final states to the result register; a rescale also passes the run
// state: 32 multiply and 61 divide steps in the serial unit, one bit per cycle.
// One measurement is in work at a time; a new one is taken as soon as the
// previous result sits in the output register. A stalled result holds the
// block in its final state only when the output register is still full.
// Reset is asynchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module ref_clock_convergence_loop (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [rccl_pkg::TgtW-1:0] cfg_wdata_i,
  rccl_meas_if.sink                 meas_i,
  rccl_res_if.source                result_o
);
  import rccl_pkg::*;

  state_e            state_q, state_d;
  logic [TgtW-1:0]   target_q;
  logic [MeasW-1:0]  meas_q;
  logic [MeasW-1:0]  diff_q;
  logic [RefW-1:0]   est_q;
  logic [IterW-1:0]  iter_q;
  status_e           pend_status_q;
  logic [RefW-1:0]   pend_ref_q;

  logic              res_valid_q;
  logic [RefW-1:0]   res_ref_q;
  logic [IterW-1:0]  res_iter_q;
  status_e           res_status_q;

  logic              meas_take;
  logic              md_start;
  logic              res_load;
  logic              slot_free;
  logic              early_end;
  status_e           early_status;
  logic [IterW-1:0]  iter_next;
  logic              diff_small;
  logic [TgtW:0]     diff_x200;
  logic              quot_bad;
  status_e           run_status;
  md_res_t           md_res;

  rccl_muldiv u_muldiv (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (md_start),
    .est_i    (est_q),
    .meas_i   (meas_q),
    .target_i (target_q),
    .res_o    (md_res)
  );

  // Decisions on the current request
  always_comb begin
    iter_next  = iter_q + 1'b1;
    diff_small = (diff_q[MeasW-1:DiffW] == '0);
    diff_x200  = {1'b0, diff_q[DiffW-1:0], 7'b0} + {2'b0, diff_q[DiffW-1:0], 6'b0}
               + {5'b0, diff_q[DiffW-1:0], 3'b0};
    early_end    = 1'b1;
    early_status = ST_FAILED;
    if (target_q == '0 || meas_q == '0) begin
      early_status = ST_FAILED;
    end else if (diff_small && diff_x200 <= {1'b0, target_q}) begin
      early_status = ST_CONVERGED;
    end else begin
      early_end = 1'b0;
    end
    quot_bad = md_res.ovf || md_res.quot < MinEstimate || md_res.quot > MaxEstimate;
    if (quot_bad) begin
      run_status = ST_FAILED;
    end else if (iter_next >= MaxIterations) begin
      run_status = ST_LIMIT;
    end else begin
      run_status = ST_CONTINUE;
    end
  end

  assign slot_free = !res_valid_q || result_o.ready;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (meas_i.valid) state_d = S_DIFF;
      S_DIFF:  state_d = S_CHECK;
      S_CHECK: state_d = early_end ? S_FINAL : S_RUN;
      S_RUN:   if (md_res.done) state_d = S_FINAL;
      S_FINAL: if (slot_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    meas_take = 1'b0;
    md_start  = 1'b0;
    res_load  = 1'b0;
    unique case (state_q)
      S_IDLE:  meas_take = 1'b1;
      S_CHECK: md_start  = !early_end;
      S_FINAL: res_load  = slot_free;
      default: ;
    endcase
  end

  assign meas_i.ready = meas_take;

  // Control and run state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      target_q    <= TargetReset;
      est_q       <= StartEstimate;
      iter_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        target_q <= cfg_wdata_i;
      end
      if (res_load) begin
        res_valid_q <= 1'b1;
      end else if (result_o.ready) begin
        res_valid_q <= 1'b0;
      end
      // Advance the run, or restart it after any end
      if (res_load) begin
        if (pend_status_q == ST_CONTINUE) begin
          est_q  <= pend_ref_q;
          iter_q <= iter_next;
        end else begin
          est_q  <= StartEstimate;
          iter_q <= '0;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (meas_take && meas_i.valid) begin
      meas_q <= meas_i.measured_baud;
    end
    if (state_q == S_DIFF) begin
      diff_q <= (meas_q > {8'b0, target_q}) ? meas_q - {8'b0, target_q}
                                             : {8'b0, target_q} - meas_q;
    end
    if (state_q == S_CHECK && early_end) begin
      pend_status_q <= early_status;
      pend_ref_q    <= (early_status == ST_CONVERGED) ? est_q : '0;
    end
    if (state_q == S_RUN && md_res.done) begin
      pend_status_q <= run_status;
      pend_ref_q    <= quot_bad ? '0 : md_res.quot[RefW-1:0];
    end
    if (res_load) begin
      res_ref_q    <= pend_ref_q;
      res_iter_q   <= iter_next;
      res_status_q <= pend_status_q;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.ref_clock_hz = res_ref_q;
  assign result_o.iteration    = res_iter_q;
  assign result_o.status       = res_status_q;

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    md_res.done |-> state_q == S_RUN)
    else $error("multiply/divide result outside run state");
  a_est_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_load && pend_status_q == ST_CONTINUE) |=> est_q == res_ref_q)
    else $error("estimate not advanced to the continued result");
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_status_q == ST_FAILED) |-> res_ref_q == '0)
    else $error("failed result carries an estimate");
  a_iter_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    iter_q < MaxIterations)
    else $error("iteration count past the limit");

endmodule

@@ dv/tb_ref_clock_convergence_loop.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ref_clock_convergence_loop: testbench of the reference clock estimator
// Drives measured baud rates through the request channel and checks every
// result against a typed plan row or a cycle-free predictor of the estimate,
// the iteration count and the status. A short directed plan covers the end
// cases and the iteration limit. Random runs follow, mostly tracking a hidden
// true clock. Both channels stall in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module tb_ref_clock_convergence_loop;
  import rccl_pkg::*;

  localparam int unsigned CycleLimit  = 1000000;
  localparam int unsigned NumPhases   = 16;
  localparam int unsigned PhaseItems  = 100;
  localparam int unsigned SettleCycles = 110;
  localparam int unsigned NumRows     = 25;

  // Expected content of one result request
  typedef struct packed {
    logic [RefW-1:0]  ref_hz;
    logic [IterW-1:0] iter;
    status_e          status;
  } estimate_t;

  // One row of the directed plan; the expected fields count only if typed
  typedef struct {
    bit               set_tgt;
    logic [TgtW-1:0]  tgt;
    logic [MeasW-1:0] meas;
    bit               typed;
    logic [RefW-1:0]  ref_hz;
    logic [IterW-1:0] iter;
    status_e          status;
  } plan_row_t;

  logic             clk_i;
  logic             rst_ni;
  logic             cfg_we_i;
  logic [TgtW-1:0]  cfg_wdata_i;

  rccl_meas_if meas ();
  rccl_res_if  res ();

  ref_clock_convergence_loop dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .meas_i      (meas),
    .result_o    (res)
  );

  // Predictor state: current estimate, finished iterations, target register
  logic [RefW-1:0]  est_hz;
  logic [IterW-1:0] iter_done;
  logic [TgtW-1:0]  target_baud_q;

  estimate_t   pending_estimates [$];
  int unsigned mismatch_cnt = 0;
  int unsigned cycle_cnt = 0;
  bit          calm = 1'b0;

  plan_row_t plan [NumRows] = '{
    // fresh run, target at reset value
    '{1'b0, 24'd0, 32'd0,          1'b1, 29'd0,         4'd1, ST_FAILED},
    '{1'b0, 24'd0, 32'd115200,     1'b1, 29'd100000000, 4'd1, ST_CONVERGED},
    '{1'b0, 24'd0, 32'hFFFFFFFF,   1'b1, 29'd0,         4'd1, ST_FAILED},
    '{1'b0, 24'd0, 32'd1,          1'b1, 29'd0,         4'd1, ST_FAILED},
    // half percent tolerance edge from both sides
    '{1'b0, 24'd0, 32'd115776,     1'b1, 29'd100000000, 4'd1, ST_CONVERGED},
    '{1'b0, 24'd0, 32'd114624,     1'b1, 29'd100000000, 4'd1, ST_CONVERGED},
    // just outside tolerance, then drift on to the iteration limit
    '{1'b0, 24'd0, 32'd115777,     1'b0, 29'd0, 4'd0, ST_CONTINUE},
    '{1'b0, 24'd0, 32'd116400,     1'b0, 29'd0, 4'd0, ST_CONTINUE},
    '{1'b0, 24'd0, 32'd116400,     1'b0, 29'd0, 4'd0, ST_CONTINUE},
    '{1'b0, 24'd0, 32'd116400,     1'b0, 29'd0, 4'd0, ST_CONTINUE},
    '{1'b0, 24'd0, 32'd116400,     1'b0, 29'd0, 4'd0, ST_CONTINUE},
    '{1'b0, 24'd0, 32'd116400,     1'b0, 29'd0, 4'd0, ST_CONTINUE},
    '{1'b0, 24'd0, 32'd116400,     1'b0, 29'd0, 4'd0, ST_CONTINUE},
    '{1'b0, 24'd0, 32'd116400,     1'b0, 29'd0, 4'd0, ST_CONTINUE},
    '{1'b0, 24'd0, 32'd116400,     1'b0, 29'd0, 4'd0, ST_CONTINUE},
    '{1'b0, 24'd0, 32'd116400,     1'b0, 29'd0, 4'd0, ST_CONTINUE},
    '{1'b0, 24'd0, 32'd116400,     1'b0, 29'd0, 4'd0, ST_CONTINUE},
    '{1'b0, 24'd0, 32'd116400,     1'b0, 29'd0, 4'd0, ST_CONTINUE},
    // zero and largest target
    '{1'b1, 24'd0,        32'd115200,   1'b1, 29'd0,         4'd1, ST_FAILED},
    '{1'b1, 24'hFFFFFF,   32'd16777215, 1'b1, 29'd100000000, 4'd1, ST_CONVERGED},
    // target of one: above the top limit, exactly on it, converge, then rescale and fail on zero
    '{1'b1, 24'd1,        32'd5,        1'b1, 29'd0,         4'd1, ST_FAILED},
    '{1'b0, 24'd0,        32'd4,        1'b0, 29'd0, 4'd0, ST_CONTINUE},
    '{1'b0, 24'd0,        32'd1,        1'b0, 29'd0, 4'd0, ST_CONTINUE},
    '{1'b0, 24'd0,        32'd2,        1'b0, 29'd0, 4'd0, ST_CONTINUE},
    '{1'b0, 24'd0,        32'd0,        1'b0, 29'd0, 4'd0, ST_CONTINUE}
  };

  // Compute the result of one measurement and advance the run state
  function automatic estimate_t advance_estimator(input logic [MeasW-1:0] m);
    estimate_t        r;
    logic [63:0]      diff;
    logic [63:0]      quo;
    logic [IterW-1:0] n;
    n = iter_done + 1'b1;
    r.ref_hz = '0;
    r.iter = n;
    if (target_baud_q == '0 || m == '0) begin
      r.status = ST_FAILED;
    end else begin
      diff = (64'(m) > 64'(target_baud_q)) ? 64'(m) - 64'(target_baud_q)
                                           : 64'(target_baud_q) - 64'(m);
      if (diff * 64'd200 <= 64'(target_baud_q)) begin
        r.status = ST_CONVERGED;
        r.ref_hz = est_hz;
      end else begin
        quo = (64'(est_hz) * 64'(m)) / 64'(target_baud_q);
        if (quo > 64'hFFFFFFFF || quo < 64'(MinEstimate) || quo > 64'(MaxEstimate)) begin
          r.status = ST_FAILED;
        end else if (n >= MaxIterations) begin
          r.status = ST_LIMIT;
          r.ref_hz = quo[RefW-1:0];
        end else begin
          r.status = ST_CONTINUE;
          r.ref_hz = quo[RefW-1:0];
        end
      end
    end
    // Keep the run going only on continue, else restart it
    if (r.status == ST_CONTINUE) begin
      est_hz = r.ref_hz;
      iter_done = n;
    end else begin
      est_hz = StartEstimate;
      iter_done = '0;
    end
    return r;
  endfunction

  // Offer one measurement, wait for the handshake, record the expectation
  task automatic send_measurement(input logic [MeasW-1:0] m, input bit typed,
                                  input estimate_t fixed);
    estimate_t e;
    if (!calm && $urandom_range(0, 3) == 0) begin
      meas.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
    meas.valid <= 1'b1;
    meas.measured_baud <= m;
    @(posedge clk_i);
    while (!meas.ready) @(posedge clk_i);
    e = advance_estimator(m);
    pending_estimates.push_back(typed ? fixed : e);
  endtask

  // Drop valid and wait until every expected result has come out
  task automatic drain_results(input int unsigned settle);
    meas.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_estimates.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic write_target_baud(input logic [TgtW-1:0] t);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= t;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    target_baud_q = t;
  endtask

  task automatic flag_result(input string what);
    mismatch_cnt++;
    if (mismatch_cnt <= 10) $display("MISMATCH %s", what);
  endtask

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Cycle limit
  initial begin
    while (cycle_cnt < CycleLimit) begin
      @(posedge clk_i);
      cycle_cnt++;
    end
    $display("ref_clock_convergence_loop verification failed");
    $finish;
  end

  // Result side: hold ready low in random bursts
  initial begin
    int unsigned n;
    res.ready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        n = $urandom_range(1, 12);
        res.ready <= 1'b0;
        repeat (n) @(posedge clk_i);
      end
      res.ready <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  end

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    estimate_t want;
    if (rst_ni && res.valid && res.ready) begin
      if (pending_estimates.size() == 0) begin
        flag_result($sformatf("unexpected result ref=%0d iter=%0d status=%0d",
                              res.ref_clock_hz, res.iteration, res.status));
      end else begin
        want = pending_estimates.pop_front();
        if (res.ref_clock_hz !== want.ref_hz || res.iteration !== want.iter ||
            res.status !== want.status) begin
          flag_result($sformatf("exp ref=%0d iter=%0d status=%0d, got ref=%0d iter=%0d status=%0d",
                                want.ref_hz, want.iter, want.status,
                                res.ref_clock_hz, res.iteration, res.status));
        end
      end
    end
  end

  // Stimulus
  initial begin
    estimate_t        fixed;
    int unsigned      true_hz;
    longint           bias;
    longint           jit;
    longint           v;
    logic [MeasW-1:0] m;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    meas.valid = 1'b0;
    meas.measured_baud = '0;
    est_hz = StartEstimate;
    iter_done = '0;
    target_baud_q = TargetReset;
    true_hz = 100000000;
    bias = 0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Walk the directed plan
    foreach (plan[i]) begin
      if (plan[i].set_tgt) begin
        drain_results(4);
        write_target_baud(plan[i].tgt);
      end
      fixed.ref_hz = plan[i].ref_hz;
      fixed.iter = plan[i].iter;
      fixed.status = plan[i].status;
      send_measurement(plan[i].meas, plan[i].typed, fixed);
    end

    // Random phases, each with its own target; the last one runs without stalls
    for (int unsigned p = 0; p < NumPhases; p++) begin
      drain_results(4);
      calm = (p == NumPhases - 1);
      case ($urandom_range(0, 9))
        0:       write_target_baud(24'hFFFFFF);
        1:       write_target_baud(24'd1);
        2:       write_target_baud(24'd0);
        3:       write_target_baud(24'd115200);
        4:       write_target_baud(24'd9600);
        5:       write_target_baud(TgtW'($urandom_range(2, 1000)));
        default: write_target_baud(TgtW'($urandom_range(1000, 24'hFFFFFF)));
      endcase
      for (int unsigned k = 0; k < PhaseItems; k++) begin
        // A fresh run gets a new hidden clock and either no bias or a steady one
        if (iter_done == '0) begin
          true_hz = $urandom_range(1000000, 400000000);
          bias = ($urandom_range(0, 3) == 0) ? longint'(target_baud_q / 80) + 1 : 0;
        end
        case ($urandom_range(0, 9))
          0: m = $urandom;
          1: begin
            case ($urandom_range(0, 3))
              0:       m = '0;
              1:       m = '1;
              default: m = MeasW'($urandom_range(0, 2 * int'(target_baud_q) + 1));
            endcase
          end
          default: begin
            // Measure as the hidden clock would at the current estimate
            v = longint'((64'(target_baud_q) * 64'(true_hz)) / 64'(est_hz)) + bias;
            jit = $urandom_range(0, 1) ? longint'($urandom_range(0, target_baud_q / 400)) : 0;
            v = $urandom_range(0, 1) ? v + jit : v - jit;
            if (v < 0) v = 0;
            if (v > 64'hFFFFFFFF) v = 64'hFFFFFFFF;
            m = v[MeasW-1:0];
          end
        endcase
        send_measurement(m, 1'b0, fixed);
      end
    end

    // Drain, allow a full rescale to pass, then report
    drain_results(SettleCycles);
    if (mismatch_cnt == 0 && pending_estimates.size() == 0) begin
      $display("ref_clock_convergence_loop verification clean");
    end else begin
      $display("ref_clock_convergence_loop verification failed");
    end
    $finish;
  end

endmodule
